// ===== src/lzd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_pkg
// Types, constants and command/status structs for the LZ byte stream decompressor.
// ----------------------------------------------------------------------------
package lzd_pkg;

  localparam int DEFAULT_LANES = 8;
  localparam logic [23:0] TOTAL_LEN_RESET = 24'd65536;

  typedef enum logic [2:0] {
    PH_CTRL     = 3'd0,
    PH_LIT_EXT  = 3'd1,
    PH_LEN_EXT  = 3'd2,
    PH_LITERALS = 3'd3,
    PH_OFFSET   = 3'd4,
    PH_EMIT     = 3'd5
  } phase_t;

  // controller -> datapath
  typedef struct packed {
    logic       put;       // write one byte into history and pack lane
    logic [1:0] src;       // byte source
    logic       rd;        // register the history entry at the copy source
    logic       flush;     // emit the packed word
    logic       last;      // last result of this request
    logic       done;      // stream done flag on this result
    logic       set_dist;  // capture distance from input byte
  } dp_cmd_t;

  localparam logic [1:0] SRC_INPUT = 2'd0;
  localparam logic [1:0] SRC_ZERO  = 2'd1;
  localparam logic [1:0] SRC_HIST  = 2'd2;

  // datapath -> controller
  typedef struct packed {
    logic       out_busy;  // output register still holds a result
    logic       lanes_full;
    logic       lanes_empty;
    logic       reached;   // bytes written >= total length
  } dp_stat_t;

endpackage

// ===== src/lzd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_datapath
// History memory, byte counter, lane packer and output register.
// ----------------------------------------------------------------------------
module lzd_datapath import lzd_pkg::*; #(
  parameter int OUT_LANES = DEFAULT_LANES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            in_byte,
  input  logic [23:0]           total_length,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [63:0]           out_bytes,
  output logic [3:0]            out_count,
  output logic                  last_of_run,
  output logic                  stream_done
);

  localparam int LW = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;

  logic [7:0]  hist [256];
  logic [7:0]  hist_rd;
  logic        hist_blank;   // copy source lies before the first byte written
  logic [24:0] bytes_written;
  logic [8:0]  copy_dist;
  logic [7:0]  rd_addr;
  logic [7:0]  wr_byte;
  logic [63:0] pack;
  logic [3:0]  lanes;
  logic [LW-1:0] lane_idx;

  // a distance of 256 wraps onto the slot about to be written
  assign rd_addr = 8'(bytes_written[7:0] - copy_dist[7:0]);

  // a registered history read precedes each copied put, so a distance of 1 sees the
  // byte put just before
  always_ff @(posedge clk) begin
    if (cmd.put) hist[bytes_written[7:0]] <= wr_byte;
    if (cmd.rd) hist_rd <= hist[rd_addr];
  end

  always_comb begin
    case (cmd.src)
      SRC_INPUT: wr_byte = in_byte;
      SRC_HIST:  wr_byte = hist_blank ? 8'd0 : hist_rd;
      default:   wr_byte = 8'd0;
    endcase
  end

  assign lane_idx = lanes[LW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_written <= '0;
      lanes <= '0;
      pack <= '0;
      out_valid <= 1'b0;
      out_bytes <= '0;
      out_count <= '0;
      last_of_run <= 1'b0;
      stream_done <= 1'b0;
      copy_dist <= 9'd256;
      hist_blank <= 1'b0;
    end else begin
      if (cmd.set_dist) copy_dist <= (in_byte == 8'd0) ? 9'd256 : {1'b0, in_byte};
      if (cmd.rd) hist_blank <= (bytes_written < {16'd0, copy_dist});
      if (cmd.put) begin
        bytes_written <= bytes_written + 25'd1;
        pack[lane_idx*8 +: 8] <= wr_byte;
        lanes <= lanes + 4'd1;
      end else if (cmd.flush) begin
        lanes <= '0;
        pack <= '0;
      end
      if (cmd.flush) begin
        out_valid <= 1'b1;
        out_bytes <= pack;
        out_count <= lanes;
        last_of_run <= cmd.last;
        stream_done <= cmd.done;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.out_busy = out_valid && out_stall;
  assign stat.lanes_full = (lanes == 4'(OUT_LANES));
  assign stat.lanes_empty = (lanes == 4'd0);
  assign stat.reached = (bytes_written >= {1'b0, total_length});

endmodule

// ===== src/lzd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzd_ctrl
// Token parser and emission sequencer.
// ----------------------------------------------------------------------------
module lzd_ctrl import lzd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  phase_t     phase, phase_next;
  phase_t     resume, resume_next;   // parse phase after generation
  logic [7:0] control_byte, control_byte_next;
  logic [7:0] literals_left, literals_left_next;
  logic [7:0] run_length, run_length_next;
  logic [8:0] work, work_next;     // bytes left to generate
  logic       copy, copy_next;     // generated bytes come from history
  logic       rd_done, rd_done_next; // history read issued for next copy byte
  logic       finished, finished_next;
  logic       tok_end, tok_end_next; // generation ends the token
  logic       acc;
  logic [7:0] cb;
  logic [7:0] ll;
  logic [7:0] rl;
  logic       count_known;
  logic       len_known;
  logic       end_now;

  assign in_stall = (phase == PH_EMIT);
  assign acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_CTRL;
      resume <= PH_CTRL;
      control_byte <= '0;
      literals_left <= '0;
      run_length <= '0;
      work <= '0;
      copy <= 1'b0;
      rd_done <= 1'b0;
      finished <= 1'b0;
      tok_end <= 1'b0;
    end else begin
      phase <= phase_next;
      resume <= resume_next;
      control_byte <= control_byte_next;
      literals_left <= literals_left_next;
      run_length <= run_length_next;
      work <= work_next;
      copy <= copy_next;
      rd_done <= rd_done_next;
      finished <= finished_next;
      tok_end <= tok_end_next;
    end
  end

  always_comb begin
    phase_next = phase;
    resume_next = resume;
    control_byte_next = control_byte;
    literals_left_next = literals_left;
    run_length_next = run_length;
    work_next = work;
    copy_next = copy;
    rd_done_next = rd_done;
    finished_next = finished;
    tok_end_next = tok_end;
    cmd = '0;
    cb = control_byte;
    ll = literals_left;
    rl = run_length;
    count_known = 1'b0;
    len_known = 1'b0;
    end_now = 1'b0;
    if (phase == PH_EMIT) begin
      if (work == 9'd0) begin
        // final result of this request; an empty token only reports the end
        if (!stat.out_busy) begin
          end_now = tok_end && stat.reached;
          cmd.flush = end_now || !stat.lanes_empty;
          cmd.last = 1'b1;
          cmd.done = end_now;
          if (end_now) finished_next = 1'b1;
          phase_next = resume;
        end
      end else if (stat.lanes_full) begin
        if (!stat.out_busy) cmd.flush = 1'b1;
      end else if (copy && !rd_done) begin
        cmd.rd = 1'b1;
        rd_done_next = 1'b1;
      end else begin
        cmd.put = 1'b1;
        cmd.src = copy ? SRC_HIST : SRC_ZERO;
        rd_done_next = 1'b0;
        work_next = work - 9'd1;
      end
    end else if (acc && !finished) begin
      case (phase)
        PH_LIT_EXT: begin
          ll = (in_byte == 8'd0) ? 8'd255 : in_byte - 8'd1;
          count_known = 1'b1;
        end
        PH_LEN_EXT: begin
          rl = in_byte;
          len_known = 1'b1;
        end
        PH_LITERALS: begin
          // put this literal now, the payload may change after acceptance
          cmd.put = 1'b1;
          cmd.src = SRC_INPUT;
          ll = literals_left - 8'd1;
          phase_next = PH_EMIT;
          work_next = '0;
          copy_next = 1'b0;
          tok_end_next = 1'b0;
          if (ll != 8'd0) resume_next = PH_LITERALS;
          else if (cb[3]) resume_next = PH_OFFSET;
          else begin
            work_next = {1'b0, rl};
            tok_end_next = 1'b1;
            resume_next = PH_CTRL;
          end
        end
        PH_OFFSET: begin
          cmd.set_dist = 1'b1;
          work_next = {1'b0, rl} + 9'd2;
          copy_next = 1'b1;
          tok_end_next = 1'b1;
          resume_next = PH_CTRL;
          phase_next = PH_EMIT;
        end
        default: begin
          cb = in_byte;
          if (in_byte[2:0] == 3'd0) phase_next = PH_LIT_EXT;
          else begin
            ll = {5'd0, in_byte[2:0]} - 8'd1;
            count_known = 1'b1;
          end
        end
      endcase
      // literal count known: take the length from the nibble or wait for it
      if (count_known) begin
        if (cb[7:4] == 4'd0) phase_next = PH_LEN_EXT;
        else begin
          rl = {4'd0, cb[7:4]};
          len_known = 1'b1;
        end
      end
      // length known: pick literals, offset or zero run
      if (len_known) begin
        if (ll != 8'd0) phase_next = PH_LITERALS;
        else if (cb[3]) phase_next = PH_OFFSET;
        else begin
          phase_next = PH_EMIT;
          work_next = {1'b0, rl};
          copy_next = 1'b0;
          tok_end_next = 1'b1;
          resume_next = PH_CTRL;
        end
      end
      control_byte_next = cb;
      literals_left_next = ll;
      run_length_next = rl;
    end
  end

endmodule

// ===== src/lz_byte_stream_decompressor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lz_byte_stream_decompressor_top
// LZ77 byte stream decompressor with 256-byte history.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall moves one compressed byte per request.
// Output channel out_valid/out_stall moves up to OUT_LANES bytes per result,
// with out_count, last_of_run on the final result of an input byte and
// stream_done once a token reaches total_length.
// Configuration channel cfg_valid/cfg_ready writes total_length (reset 65536).
// Header bytes are taken one per cycle while no request generates. The accepting
// cycle of a literal byte puts it; the emit phase then loads the output register
// with its result. A zero run puts its bytes and flushes each full word; a
// history copy does the same, but each copied byte needs a registered history
// read before its write. An empty token still enters the emit phase to finish.
// in_stall is high while a request generates; each result load waits while
// out_stall holds the output register, which keeps its payload.
// Reset (rst, synchronous) returns the parser to the control byte; history
// contents are not cleared, but copies reaching before the first byte read
// zero. After stream_done every input byte is swallowed until reset.
// ----------------------------------------------------------------------------
module lz_byte_stream_decompressor_top import lzd_pkg::*; #(
  parameter int OUT_LANES = DEFAULT_LANES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_count,
  output logic        last_of_run,
  output logic        stream_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);

  logic [23:0] total_length;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) total_length <= TOTAL_LEN_RESET;
    else if (cfg_valid && cfg_ready) total_length <= cfg_data;
  end

  lzd_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .in_byte, .stat, .cmd
  );

  lzd_datapath #(.OUT_LANES(OUT_LANES)) u_dp (
    .clk, .rst, .in_byte, .total_length, .cmd, .stat,
    .out_valid, .out_stall, .out_bytes, .out_count, .last_of_run, .stream_done
  );

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_bytes))
    else $error("output result changed while stalled");
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_count <= 4'(OUT_LANES))
    else $error("out_count beyond lanes");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_done |-> last_of_run)
    else $error("done without last");

endmodule

// ===== test/tb_lz_byte_stream_decompressor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lz_byte_stream_decompressor_top
// Self-checking bench for the LZ byte stream decompressor.
// ----------------------------------------------------------------------------
// Feeds whole tokens, with some stray bytes mixed in. The token content is
// random. A predictor in the bench works out the packed output words, and a
// monitor compares each word with the oldest one the predictor holds. The
// total length is changed between phases and the sender and receiver idle at
// random. The run ends by closing the stream with an empty token.
// ----------------------------------------------------------------------------
module tb_lz_byte_stream_decompressor_top;
  import lzd_pkg::*;

  localparam int LANES       = 8;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 40;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic        done;
  } lz_word_t;

  class lz_output_tracker;
    phase_t      phase;
    logic [7:0]  ctrl;
    logic [7:0]  lit_left;
    logic [7:0]  run_len;
    logic [7:0]  hist [256];
    logic [24:0] written;
    logic [23:0] total_len;
    bit          stopped;
    bit          done_now;
    logic [7:0]  made [$];
    lz_word_t    pending [$];
    int          errors;
    int          words_seen;
    int          bytes_taken;

    function new();
      phase = PH_CTRL;
      ctrl = 8'd0;
      lit_left = 8'd0;
      run_len = 8'd0;
      foreach (hist[i]) hist[i] = 8'd0;
      written = 25'd0;
      total_len = TOTAL_LEN_RESET;
      stopped = 0;
      done_now = 0;
      errors = 0;
      words_seen = 0;
      bytes_taken = 0;
    endfunction

    function void put(logic [7:0] b);
      hist[written[7:0]] = b;
      written = written + 25'd1;
      made.push_back(b);
    endfunction

    function void end_token();
      phase = PH_CTRL;
      if (written >= {1'b0, total_len}) begin
        stopped = 1;
        done_now = 1;
      end
    endfunction

    function void tail();
      if (ctrl[3]) begin
        phase = PH_OFFSET;
      end else begin
        for (int i = 0; i < run_len; i++) put(8'd0);
        end_token();
      end
    endfunction

    function void body();
      if (lit_left != 0) phase = PH_LITERALS;
      else tail();
    endfunction

    function void after_count();
      if (ctrl[7:4] == 4'd0) begin
        phase = PH_LEN_EXT;
      end else begin
        run_len = {4'd0, ctrl[7:4]};
        body();
      end
    endfunction

    function void take_byte(logic [7:0] b);
      int       back;
      int       n;
      lz_word_t w;
      bytes_taken++;
      if (stopped) return;
      done_now = 0;
      made.delete();
      case (phase)
        PH_LIT_EXT: begin
          lit_left = (b == 8'd0) ? 8'd255 : b - 8'd1;
          after_count();
        end
        PH_LEN_EXT: begin
          run_len = b;
          body();
        end
        PH_LITERALS: begin
          put(b);
          lit_left = lit_left - 8'd1;
          if (lit_left == 0) tail();
        end
        PH_OFFSET: begin
          back = (b == 8'd0) ? 256 : b;
          for (int i = 0; i < run_len + 2; i++)
            put(hist[(written[7:0] - back) & 8'hff]);
          end_token();
        end
        default: begin
          ctrl = b;
          if (b[2:0] == 3'd0) begin
            phase = PH_LIT_EXT;
          end else begin
            lit_left = {5'd0, b[2:0]} - 8'd1;
            after_count();
          end
        end
      endcase
      if (made.size() == 0) begin
        if (done_now) begin
          w.data = 64'd0; w.count = 4'd0; w.last = 1; w.done = 1;
          pending.push_back(w);
        end
        return;
      end
      while (made.size() > 0) begin
        w.data = 64'd0;
        n = 0;
        while (n < LANES && made.size() > 0) begin
          w.data[8*n +: 8] = made.pop_front();
          n++;
        end
        w.count = n[3:0];
        w.last = (made.size() == 0);
        w.done = w.last && done_now;
        pending.push_back(w);
      end
    endfunction

    function void check_word(lz_word_t got);
      lz_word_t exp_w;
      words_seen++;
      if (pending.size() == 0) begin
        $display("%0t: expected no result, actual data=%h count=%0d",
                 $time, got.data, got.count);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.data !== exp_w.data) begin
        $display("%0t: out_bytes expected %h actual %h", $time, exp_w.data, got.data);
        errors++;
      end
      if (got.count !== exp_w.count) begin
        $display("%0t: out_count expected %0d actual %0d", $time, exp_w.count, got.count);
        errors++;
      end
      if (got.last !== exp_w.last) begin
        $display("%0t: last_of_run expected %b actual %b", $time, exp_w.last, got.last);
        errors++;
      end
      if (got.done !== exp_w.done) begin
        $display("%0t: stream_done expected %b actual %b", $time, exp_w.done, got.done);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_bytes;
  logic [3:0]  out_count;
  logic        last_of_run;
  logic        stream_done;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [23:0] cfg_data;

  lz_output_tracker tracker;
  int send_idle_pct;
  int stall_pct;
  int cycles;
  int token_bytes;

  lz_byte_stream_decompressor_top #(.OUT_LANES(LANES)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_bytes(out_bytes), .out_count(out_count),
    .last_of_run(last_of_run), .stream_done(stream_done),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    tracker = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_byte = 8'd0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 24'd0;
    send_idle_pct = 0;
    stall_pct = 0;
    cycles = 0;
    token_bytes = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[lz_byte_stream_decompressor_top] ERROR");
      $finish;
    end
  end

  // random back-pressure on the result side
  always @(negedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    lz_word_t w;
    if (!rst && out_valid && !out_stall) begin
      w.data = out_bytes; w.count = out_count;
      w.last = last_of_run; w.done = stream_done;
      tracker.check_word(w);
    end
  end

  // call at a falling edge; returns at a falling edge with valid still high,
  // so the caller either sends again at once or drops valid
  task automatic send_byte(input logic [7:0] b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_byte <= 8'($urandom_range(255));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(b);
    token_bytes++;
    @(negedge clk);
  endtask

  task automatic write_total(input logic [23:0] v);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    tracker.total_len = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending.size() > 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic emit_token(input logic [7:0] c, input logic [7:0] lit_ext,
                            input logic [7:0] len_ext, input logic [7:0] offs);
    int lits;
    send_byte(c);
    if (c[2:0] == 3'd0) begin
      send_byte(lit_ext);
      lits = (lit_ext == 8'd0) ? 255 : lit_ext - 1;
    end else begin
      lits = c[2:0] - 1;
    end
    if (c[7:4] == 4'd0) send_byte(len_ext);
    for (int i = 0; i < lits; i++) send_byte(8'($urandom_range(255)));
    if (c[3]) send_byte(offs);
  endtask

  task automatic random_token();
    logic [7:0] c;
    logic [7:0] le;
    logic [7:0] re;
    c = 8'($urandom_range(255));
    le = ($urandom_range(49) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 9));
    re = ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(12));
    emit_token(c, le, re, 8'($urandom_range(255)));
  endtask

  task automatic random_phase(input int items);
    token_bytes = 0;
    while (token_bytes < items) begin
      if ($urandom_range(9) == 0) send_byte(8'($urandom_range(255)));
      else random_token();
    end
  endtask

  initial begin
    logic [23:0] totals [3];
    totals[0] = 24'h800000;
    totals[1] = 24'(24'd1048576 + $urandom_range(4095));
    totals[2] = 24'hfffff0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_total(24'hffffff);

    // copy from unwritten history, then literal/run extremes
    emit_token(8'hf9, 8'd0, 8'd0, 8'd200);
    emit_token(8'h37, 8'd0, 8'd0, 8'd1);
    emit_token(8'h08, 8'd0, 8'd255, 8'd0);
    emit_token(8'h02, 8'd0, 8'd255, 8'd0);
    emit_token(8'h01, 8'd0, 8'd0, 8'd0);
    emit_token(8'h09, 8'd1, 8'd0, 8'd255);
    emit_token(8'h10, 8'd3, 8'd0, 8'd0);
    emit_token(8'hff, 8'd0, 8'd0, 8'd3);
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      if (p > 0) write_total(totals[p-1]);
      random_phase(25);
      drain();
    end

    // close the stream with an empty token, then check that input is ignored
    send_idle_pct = 12; stall_pct = 12;
    write_total(24'd1);
    emit_token(8'h01, 8'd0, 8'd0, 8'd0);
    for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(255)));
    drain();

    $display("Covered %0d input bytes and %0d output words over five length settings.",
             tracker.bytes_taken, tracker.words_seen);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("[lz_byte_stream_decompressor_top] OK");
    end else begin
      $display("[lz_byte_stream_decompressor_top] ERROR");
    end
    $finish;
  end

endmodule
